/* hdl/dtf_pkg.sv */
// Shared types, constants and power-of-ten tables for the decimal text to float block.
// The tables are built at elaboration; no other file is needed.
package dtf_pkg;

  localparam int MaxSigDigits = 8;
  localparam int PosBits      = 16;
  localparam int SigBits      = 4;
  localparam int MantBits     = 27;
  localparam int DexpBits     = 16;
  localparam int XvalBits     = 10;
  localparam int PosPowCount  = 39;
  localparam int NegPowCount  = 38;

  localparam logic [31:0] FloatInf = 32'h7F80_0000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SPACE, PH_SIGNED, PH_INF1, PH_INF2, PH_MANT, PH_EXP_E, PH_EXP_SIGN, PH_EXP_DIG
  } phase_e;

  typedef enum logic [1:0] {JOB_NONE, JOB_INF, JOB_NUM} job_kind_e;

  typedef enum logic [2:0] {BK_IDLE, BK_NORM, BK_MUL, BK_RND, BK_DONE} back_state_e;

  typedef struct packed {
    job_kind_e                   kind;
    logic                        neg;
    logic [MantBits-1:0]         mant;
    logic [SigBits-1:0]          sig;
    logic signed [DexpBits-1:0]  dexp;
    logic [PosBits-1:0]          end_pos;
  } job_t;

  typedef logic [31:0] pos_pow_t [PosPowCount];
  typedef logic [31:0] neg_pow_t [NegPowCount];

  function automatic pos_pow_t gen_pos_pow();
    pos_pow_t     t;
    logic [127:0] v;
    logic [127:0] rem;
    logic [127:0] half;
    logic [127:0] mq;
    int           n;
    int           sh;
    v = 128'd1;
    for (int k = 0; k < PosPowCount; k++) begin
      if (k > 0) begin
        v = v * 128'd10;
      end
      n = 0;
      for (int i = 0; i < 128; i++) begin
        if (v[i]) begin
          n = i;
        end
      end
      if (n <= 23) begin
        mq = v << (23 - n);
      end else begin
        sh   = n - 23;
        rem  = v & ((128'd1 << sh) - 128'd1);
        half = 128'd1 << (sh - 1);
        mq   = v >> sh;
        if (rem > half || (rem == half && mq[0])) begin
          mq = mq + 128'd1;
        end
        if (mq == (128'd1 << 24)) begin
          mq = mq >> 1;
          n  = n + 1;
        end
      end
      t[k] = {1'b0, 8'(n + 127), mq[22:0]};
    end
    return t;
  endfunction

  function automatic neg_pow_t gen_neg_pow();
    neg_pow_t     t;
    logic [191:0] d;
    logic [191:0] r;
    logic [191:0] q;
    logic [191:0] rem;
    logic [191:0] half;
    logic [191:0] mq;
    int           n;
    int           sh;
    d = 192'd1;
    for (int k = 0; k < NegPowCount; k++) begin
      if (k > 0) begin
        d = d * 192'd10;
      end
      r = '0;
      q = '0;
      for (int i = 191; i >= 0; i--) begin
        r = {r[190:0], (i == 160)};
        if (r >= d) begin
          r    = r - d;
          q[i] = 1'b1;
        end
      end
      n = 0;
      for (int i = 0; i < 192; i++) begin
        if (q[i]) begin
          n = i;
        end
      end
      sh   = n - 23;
      rem  = q & ((192'd1 << sh) - 192'd1);
      half = 192'd1 << (sh - 1);
      mq   = q >> sh;
      if (rem > half || (rem == half && (r != '0 || mq[0]))) begin
        mq = mq + 192'd1;
      end
      if (mq == (192'd1 << 24)) begin
        mq = mq >> 1;
        n  = n + 1;
      end
      t[k] = {1'b0, 8'(n - 160 + 127), mq[22:0]};
    end
    return t;
  endfunction

  localparam pos_pow_t PosPow = gen_pos_pow();
  localparam neg_pow_t NegPow = gen_neg_pow();

endpackage

/* hdl/dtf_front.sv */
// Front end: parses one text byte per transfer and posts one job per finished string.
// Depends on dtf_pkg.
module dtf_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [7:0]    text_byte_i,
  input  logic          string_start_i,
  input  logic          full_i,
  output logic          push_o,
  output dtf_pkg::job_t job_o
);
  import dtf_pkg::*;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPoint = 8'h2E;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChUpI   = 8'h49;
  localparam logic [7:0] ChLoI   = 8'h69;
  localparam logic [7:0] ChUpN   = 8'h4E;
  localparam logic [7:0] ChLoN   = 8'h6E;
  localparam logic [7:0] ChUpF   = 8'h46;
  localparam logic [7:0] ChLoF   = 8'h66;
  localparam logic [7:0] ChUpE   = 8'h45;
  localparam logic [7:0] ChLoE   = 8'h65;

  phase_e                     phase_q, phase_d;
  logic [MantBits-1:0]        mant_q, mant_d;
  logic [SigBits-1:0]         sig_q, sig_d;
  logic signed [DexpBits-1:0] dexp_q, dexp_d;
  logic [XvalBits-1:0]        xval_q, xval_d;
  logic                       neg_q, neg_d, point_q, point_d, xneg_q, xneg_d;
  logic [PosBits-1:0]         pos_q, pos_d, end_q, end_d;

  logic                       accept;
  logic                       is_digit;
  logic [3:0]                 digit;
  logic                       take_m;
  logic                       finish;
  logic [PosBits-1:0]         pos_inc;
  logic signed [DexpBits:0]   e_wide;
  logic signed [DexpBits-1:0] e_fin;
  phase_e                     ph;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign is_digit   = (text_byte_i >= ChZero) && (text_byte_i <= ChNine);
  assign digit      = text_byte_i[3:0];

  always_comb begin
    phase_d = phase_q;
    mant_d  = mant_q;
    sig_d   = sig_q;
    dexp_d  = dexp_q;
    xval_d  = xval_q;
    neg_d   = neg_q;
    point_d = point_q;
    xneg_d  = xneg_q;
    pos_d   = pos_q;
    end_d   = end_q;
    push_o  = 1'b0;
    job_o   = '0;
    take_m  = 1'b0;
    finish  = 1'b0;
    ph      = PH_IDLE;
    pos_inc = '0;
    e_wide  = '0;
    e_fin   = '0;
    if (accept) begin
      if (string_start_i) begin
        phase_d = PH_SPACE;
        mant_d  = '0;
        sig_d   = '0;
        dexp_d  = '0;
        xval_d  = '0;
        neg_d   = 1'b0;
        point_d = 1'b0;
        xneg_d  = 1'b0;
        pos_d   = '0;
        end_d   = '0;
      end
      ph      = phase_d;
      pos_inc = (pos_d == '1) ? pos_d : pos_d + 1'b1;
      case (ph)
        PH_IDLE: begin
        end
        PH_SPACE, PH_SIGNED: begin
          if (ph == PH_SPACE && text_byte_i == ChSpace) begin
          end else if (ph == PH_SPACE && (text_byte_i == ChPlus || text_byte_i == ChMinus)) begin
            if (text_byte_i == ChMinus) begin
              neg_d = 1'b1;
            end
            phase_d = PH_SIGNED;
          end else if (text_byte_i == ChLoI || text_byte_i == ChUpI) begin
            phase_d = PH_INF1;
          end else if (is_digit || text_byte_i == ChPoint) begin
            take_m = 1'b1;
          end else begin
            push_o     = 1'b1;
            job_o.kind = JOB_NONE;
            phase_d    = PH_IDLE;
          end
        end
        PH_INF1: begin
          if (text_byte_i == ChLoN || text_byte_i == ChUpN) begin
            phase_d = PH_INF2;
          end else begin
            push_o     = 1'b1;
            job_o.kind = JOB_NONE;
            phase_d    = PH_IDLE;
          end
        end
        PH_INF2: begin
          push_o  = 1'b1;
          phase_d = PH_IDLE;
          if (text_byte_i == ChLoF || text_byte_i == ChUpF) begin
            job_o.kind    = JOB_INF;
            job_o.neg     = neg_d;
            job_o.end_pos = pos_inc;
          end else begin
            job_o.kind = JOB_NONE;
          end
        end
        PH_MANT: begin
          if (is_digit || (text_byte_i == ChPoint && !point_d)) begin
            take_m = 1'b1;
          end else if (text_byte_i == ChLoE || text_byte_i == ChUpE) begin
            phase_d = PH_EXP_E;
          end else begin
            finish = 1'b1;
          end
        end
        PH_EXP_E, PH_EXP_SIGN, PH_EXP_DIG: begin
          if (ph == PH_EXP_E && (text_byte_i == ChPlus || text_byte_i == ChMinus)) begin
            if (text_byte_i == ChMinus) begin
              xneg_d = 1'b1;
            end
            phase_d = PH_EXP_SIGN;
          end else if (is_digit) begin
            if (xval_d < XvalBits'(100)) begin
              xval_d = XvalBits'((xval_d << 3) + (xval_d << 1) + XvalBits'(digit));
            end
            end_d   = pos_inc;
            phase_d = PH_EXP_DIG;
          end else begin
            finish = 1'b1;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
      if (take_m) begin
        if (text_byte_i == ChPoint) begin
          point_d = 1'b1;
        end else if (sig_d < SigBits'(MaxSigDigits)) begin
          mant_d = MantBits'((mant_d << 3) + (mant_d << 1) + MantBits'(digit));
          if (mant_d != '0) begin
            sig_d = sig_d + 1'b1;
          end
          if (point_d && dexp_d != {1'b1, {(DexpBits-1){1'b0}}}) begin
            dexp_d = dexp_d - 1'b1;
          end
        end else if (!point_d && dexp_d != {1'b0, {(DexpBits-1){1'b1}}}) begin
          dexp_d = dexp_d + 1'b1;
        end
        end_d   = pos_inc;
        phase_d = PH_MANT;
      end
      if (finish) begin
        e_fin = dexp_d;
        if (ph == PH_EXP_DIG) begin
          if (xneg_d) begin
            e_wide = $signed({dexp_d[DexpBits-1], dexp_d}) - $signed({7'd0, xval_d});
          end else begin
            e_wide = $signed({dexp_d[DexpBits-1], dexp_d}) + $signed({7'd0, xval_d});
          end
          if (e_wide[DexpBits] != e_wide[DexpBits-1]) begin
            e_fin = e_wide[DexpBits] ? {1'b1, {(DexpBits-1){1'b0}}}
                                     : {1'b0, {(DexpBits-1){1'b1}}};
          end else begin
            e_fin = e_wide[DexpBits-1:0];
          end
        end
        push_o        = 1'b1;
        job_o.kind    = JOB_NUM;
        job_o.neg     = neg_d;
        job_o.mant    = mant_d;
        job_o.sig     = sig_d;
        job_o.dexp    = e_fin;
        job_o.end_pos = end_d;
        phase_d       = PH_IDLE;
      end
      if (ph != PH_IDLE) begin
        pos_d = pos_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      mant_q  <= '0;
      sig_q   <= '0;
      dexp_q  <= '0;
      xval_q  <= '0;
      neg_q   <= 1'b0;
      point_q <= 1'b0;
      xneg_q  <= 1'b0;
      pos_q   <= '0;
      end_q   <= '0;
    end else begin
      phase_q <= phase_d;
      mant_q  <= mant_d;
      sig_q   <= sig_d;
      dexp_q  <= dexp_d;
      xval_q  <= xval_d;
      neg_q   <= neg_d;
      point_q <= point_d;
      xneg_q  <= xneg_d;
      pos_q   <= pos_d;
      end_q   <= end_d;
    end
  end

endmodule

/* hdl/dtf_queue.sv */
// Two-entry job queue between the parser and the float back end.
// Depends on dtf_pkg.
module dtf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  dtf_pkg::job_t job_i,
  output logic          full_o,
  output logic          valid_o,
  input  logic          pop_i,
  output dtf_pkg::job_t job_o
);
  import dtf_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= !wr_q;
      end
      if (pop_i) begin
        rd_q <= !rd_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("Job pushed into a full queue.");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> valid_o)
    else $error("Job popped from an empty queue.");

endmodule

/* hdl/dtf_back.sv */
// Back end: converts a parsed job to IEEE single, numbers in range with a
// normalize pass and one or two rounded multiplies, into an output register.
// Depends on dtf_pkg.
module dtf_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  dtf_pkg::job_t job_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [31:0]   float_bits_o,
  output logic [15:0]   end_offset_o,
  output logic          range_error_o
);
  import dtf_pkg::*;

  back_state_e          state_q, state_d;
  logic [MantBits-1:0]  x_q, x_d;
  logic [7:0]           xexp_q, xexp_d;
  logic signed [16:0]   e_q, e_d;
  logic [SigBits-1:0]   sig_q, sig_d;
  logic                 neg_q, neg_d, sgn_q, sgn_d, more_q, more_d, ppath_q, ppath_d;
  logic                 rng_q, rng_d;
  logic [PosBits-1:0]   end_q, end_d;
  logic [31:0]          r_q, r_d, op_q, op_d;
  logic [47:0]          prod_q, prod_d;
  logic signed [10:0]   esum_q, esum_d;
  logic                 out_valid_q;
  logic [31:0]          out_bits_q;
  logic [15:0]          out_end_q;
  logic                 out_rng_q;
  logic                 load_out;

  logic signed [16:0]   et;
  logic signed [16:0]   e_neg;
  logic signed [10:0]   rexp;
  logic [47:0]          pn;
  logic [47:0]          pshift;
  logic [47:0]          pmask;
  logic [10:0]          samt;
  logic [5:0]           sa;
  logic [23:0]          m;
  logic                 g, st;
  logic [31:0]          res;

  assign load_out = (state_q == BK_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    rexp   = esum_q + $signed({10'd0, prod_q[47]});
    pn     = prod_q[47] ? prod_q : {prod_q[46:0], 1'b0};
    samt   = 11'sd1 - rexp;
    sa     = (samt > 11'd48) ? 6'd48 : samt[5:0];
    pshift = pn >> sa;
    pmask  = ~(48'hFFFF_FFFF_FFFF << sa);
    if (rexp >= 11'sd255) begin
      m   = '0;
      g   = 1'b0;
      st  = 1'b0;
      res = FloatInf;
    end else if (rexp >= 11'sd1) begin
      m   = pn[47:24];
      g   = pn[23];
      st  = |pn[22:0];
      res = {1'b0, rexp[7:0], m[22:0]} + 32'(g & (st | m[0]));
    end else begin
      m   = pshift[47:24];
      g   = pshift[23];
      st  = (|pshift[22:0]) | (|(pn & pmask));
      res = {9'd0, m[22:0]} + 32'(g & (st | m[0]));
    end
  end

  always_comb begin
    state_d = state_q;
    x_d     = x_q;
    xexp_d  = xexp_q;
    e_d     = e_q;
    sig_d   = sig_q;
    neg_d   = neg_q;
    sgn_d   = sgn_q;
    more_d  = more_q;
    ppath_d = ppath_q;
    rng_d   = rng_q;
    end_d   = end_q;
    r_d     = r_q;
    op_d    = op_q;
    prod_d  = prod_q;
    esum_d  = esum_q;
    pop_o   = 1'b0;
    et      = $signed({job_i.dexp[15], job_i.dexp}) + $signed({13'd0, job_i.sig}) - 17'sd1;
    e_neg   = -e_q;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          pop_o   = 1'b1;
          neg_d   = job_i.neg;
          end_d   = job_i.end_pos;
          sig_d   = job_i.sig;
          e_d     = $signed({job_i.dexp[15], job_i.dexp});
          x_d     = job_i.mant;
          xexp_d  = 8'd153;
          rng_d   = 1'b0;
          sgn_d   = 1'b1;
          state_d = BK_DONE;
          case (job_i.kind)
            JOB_NONE: begin
              r_d   = '0;
              sgn_d = 1'b0;
              end_d = '0;
            end
            JOB_INF: begin
              r_d = FloatInf;
            end
            default: begin
              if (job_i.mant == '0) begin
                r_d = '0;
              end else if (et > 17'sd38) begin
                r_d   = FloatInf;
                rng_d = 1'b1;
              end else if (et < -17'sd38) begin
                r_d   = '0;
                rng_d = 1'b1;
              end else begin
                state_d = BK_NORM;
              end
            end
          endcase
        end
      end
      BK_NORM: begin
        if (x_q[MantBits-1]) begin
          r_d = {1'b0, xexp_q, x_q[25:3]} + 32'(x_q[2] & ((|x_q[1:0]) | x_q[3]));
          if (!e_q[16]) begin
            op_d    = PosPow[e_q[5:0]];
            ppath_d = 1'b1;
            more_d  = 1'b0;
          end else if (e_q < -17'sd37) begin
            op_d    = NegPow[{2'b00, sig_q}];
            e_d     = e_q + $signed({13'd0, sig_q});
            ppath_d = 1'b0;
            more_d  = 1'b1;
          end else begin
            op_d    = NegPow[e_neg[5:0]];
            ppath_d = 1'b0;
            more_d  = 1'b0;
          end
          state_d = BK_MUL;
        end else begin
          x_d    = {x_q[MantBits-2:0], 1'b0};
          xexp_d = xexp_q - 8'd1;
        end
      end
      BK_MUL: begin
        prod_d  = {1'b1, r_q[22:0]} * {1'b1, op_q[22:0]};
        esum_d  = $signed({3'd0, r_q[30:23]}) + $signed({3'd0, op_q[30:23]}) - 11'sd127;
        state_d = BK_RND;
      end
      BK_RND: begin
        r_d = res;
        if (more_q) begin
          op_d    = NegPow[e_neg[5:0]];
          more_d  = 1'b0;
          state_d = BK_MUL;
        end else begin
          rng_d   = ppath_q ? (res[30:0] == FloatInf[30:0]) : (res[30:0] == '0);
          state_d = BK_DONE;
        end
      end
      BK_DONE: begin
        if (load_out) begin
          state_d = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q     <= x_d;
    xexp_q  <= xexp_d;
    e_q     <= e_d;
    sig_q   <= sig_d;
    neg_q   <= neg_d;
    sgn_q   <= sgn_d;
    more_q  <= more_d;
    ppath_q <= ppath_d;
    rng_q   <= rng_d;
    end_q   <= end_d;
    r_q     <= r_d;
    op_q    <= op_d;
    prod_q  <= prod_d;
    esum_q  <= esum_d;
    if (load_out) begin
      out_bits_q <= r_q ^ {neg_q & sgn_q, 31'd0};
      out_end_q  <= end_q[15:0];
      out_rng_q  <= rng_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign float_bits_o  = out_bits_q;
  assign end_offset_o  = out_end_q;
  assign range_error_o = out_rng_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_MUL |-> (r_q[30:23] != 8'd0) && (op_q[30:23] != 8'd0))
    else $error("Multiplier operand is not a normal number.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_RND |-> prod_q[47] || prod_q[46])
    else $error("Product lost its leading bit.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> state_q == BK_IDLE && !$past(pop_o))
    else $error("Job taken while a conversion is still open.");

endmodule

/* hdl/decimal_text_to_float.sv */
// Top level of the decimal text to float converter.
// Depends on dtf_pkg, dtf_front, dtf_queue and dtf_back.
//
// Input channel: one text byte per transfer (in_valid_i, in_stall_o). A byte with
// string_start_i set opens a new string. Unless stalled, bytes are parsed at one
// per cycle; after reset the parser is idle, dropping bytes until a string starts.
// Output channel: one result per converted string (out_valid_o, out_stall_i) with
// the IEEE single pattern, the end offset and the range flag.
// The terminating byte posts a job into a two-entry queue. The back end takes the
// job; strings with no number, infinity, zero or range cases then go straight to
// the output register, while numbers normalize the kept integer step by step and
// run one or two multiplies, each a multiply and a rounding state, before it.
// One conversion runs in the back end at a time.
// When the receiver stalls, the result holds in the output register, the back end
// waits after its next result, and once the queue is full the input is stalled.
module decimal_text_to_float (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        string_start_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] float_bits_o,
  output logic [15:0] end_offset_o,
  output logic        range_error_o
);
  import dtf_pkg::*;

  logic push, full, q_valid, pop;
  job_t job_in, job_out;

  dtf_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .text_byte_i    (text_byte_i),
    .string_start_i (string_start_i),
    .full_i         (full),
    .push_o         (push),
    .job_o          (job_in)
  );

  dtf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (pop),
    .job_o   (job_out)
  );

  dtf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (job_out),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .float_bits_o  (float_bits_o),
    .end_offset_o  (end_offset_o),
    .range_error_o (range_error_o)
  );

endmodule
